@@ hw/rtl/irig_b_frame_pulse_encoder_assert.svh @@
// ----------------------------------------------------------------------------
// IRIG-B frame pulse encoder assertion macros
// Shared concurrent assertion wrappers, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef IRIG_B_FRAME_PULSE_ENCODER_ASSERT_SVH
`define IRIG_B_FRAME_PULSE_ENCODER_ASSERT_SVH

// Condition holds on every edge out of reset.
`define IRIGB_ASSERT(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("irigb assertion failed");

// Antecedent implies consequent on the same edge.
`define IRIGB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("irigb assertion failed");

`endif

@@ hw/rtl/irigb_pkg.sv @@
// ----------------------------------------------------------------------------
// IRIG-B encoder package
// Shared types and constants of the frame pulse encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package irigb_pkg;

  localparam int unsigned CFG_W  = 8;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 4;

  localparam logic [CFG_W-1:0] SLOT_TICKS_RST  = 8'd10;
  localparam logic [CFG_W-1:0] ZERO_HIGH_RST   = 8'd2;
  localparam logic [CFG_W-1:0] ONE_HIGH_RST    = 8'd5;
  localparam logic [CFG_W-1:0] MARKER_HIGH_RST = 8'd8;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_ZERO   = 2'd0,
    KIND_ONE    = 2'd1,
    KIND_MARKER = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BUSY      = 2'd1,
    ST_BAD_MONTH = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_SLOT_TICKS  = 2'd0,
    REG_ZERO_HIGH   = 2'd1,
    REG_ONE_HIGH    = 2'd2,
    REG_MARKER_HIGH = 2'd3
  } reg_idx_e;

  // Decoded item passed from front to back
  typedef struct packed {
    op_e        op;
    logic       bad_month;
    logic [6:0] sec_bcd;
    logic [6:0] min_bcd;
    logic [6:0] hr_bcd;
    logic [9:0] doy_bcd;
    logic [7:0] yr_bcd;
  } item_t;

  typedef struct packed {
    logic [CFG_W-1:0] slot_ticks;
    logic [CFG_W-1:0] zero_high;
    logic [CFG_W-1:0] one_high;
    logic [CFG_W-1:0] marker_high;
  } cfg_t;

endpackage

@@ hw/rtl/irigb_in_if.sv @@
// ----------------------------------------------------------------------------
// IRIG-B encoder input channel
// Valid/ready channel carrying tick and load items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface irigb_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [5:0] seconds;
  logic [5:0] minutes;
  logic [4:0] hours;
  logic [4:0] day_of_month;
  logic [3:0] month;
  logic [6:0] year;

  modport source (
    output valid, operation, seconds, minutes, hours, day_of_month, month, year,
    input  ready
  );
  modport sink (
    input  valid, operation, seconds, minutes, hours, day_of_month, month, year,
    output ready
  );
endinterface

@@ hw/rtl/irigb_out_if.sv @@
// ----------------------------------------------------------------------------
// IRIG-B encoder result channel
// Valid/ready channel carrying one result per accepted item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface irigb_out_if;
  logic       valid;
  logic       ready;
  logic       line_level;
  logic       busy_res;
  logic [6:0] symbol_position;
  logic [1:0] symbol_kind;
  logic       frame_done;
  logic [1:0] status;

  modport source (
    output valid, line_level, busy_res, symbol_position, symbol_kind, frame_done, status,
    input  ready
  );
  modport sink (
    input  valid, line_level, busy_res, symbol_position, symbol_kind, frame_done, status,
    output ready
  );
endinterface

@@ hw/rtl/irigb_front.sv @@
// ----------------------------------------------------------------------------
// IRIG-B encoder front end
// Classifies input items and converts a time stamp into BCD digit groups.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module irigb_front (
  irigb_in_if.sink        in_i,
  input  logic            full_i,
  output logic            push_o,
  output irigb_pkg::item_t item_o
);

  // Days before the first of each month, non-leap
  function automatic logic [8:0] days_before(input logic [3:0] mon);
    logic [8:0] d;
    case (mon)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // v / 10 for v < 128 via reciprocal multiply
  function automatic logic [3:0] div10(input logic [6:0] v);
    logic [14:0] p;
    p = 15'(v) * 15'd205;
    return 4'(p >> 11);
  endfunction

  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [3:0] tens;
    logic [6:0] units;
    tens  = div10(v);
    units = v - 7'(tens) * 7'd10;
    return {tens, units[3:0]};
  endfunction

  logic [8:0] doy;
  logic       leap;
  logic [1:0] hund;
  logic [6:0] rem;
  logic [7:0] sec_b, min_b, hr_b, yr_b, rem_b;

  assign leap = (in_i.month > 4'd2) && (in_i.year[1:0] == 2'b00);
  assign doy  = 9'(in_i.day_of_month) + days_before(in_i.month) + 9'(leap);

  always_comb begin
    if (doy >= 9'd300) begin
      hund = 2'd3;
    end else if (doy >= 9'd200) begin
      hund = 2'd2;
    end else if (doy >= 9'd100) begin
      hund = 2'd1;
    end else begin
      hund = 2'd0;
    end
  end

  assign rem   = 7'(doy - 9'(hund) * 9'd100);
  assign rem_b = to_bcd(rem);
  assign sec_b = to_bcd(7'(in_i.seconds));
  assign min_b = to_bcd(7'(in_i.minutes));
  assign hr_b  = to_bcd(7'(in_i.hours));
  assign yr_b  = to_bcd(in_i.year);

  always_comb begin
    item_o.op        = irigb_pkg::op_e'(in_i.operation);
    item_o.bad_month = (in_i.month == 4'd0) || (in_i.month > 4'd12);
    item_o.sec_bcd   = sec_b[6:0];
    item_o.min_bcd   = min_b[6:0];
    item_o.hr_bcd    = hr_b[6:0];
    item_o.doy_bcd   = {hund, rem_b};
    item_o.yr_bcd    = yr_b;
  end

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

endmodule

@@ hw/rtl/irigb_queue.sv @@
// ----------------------------------------------------------------------------
// IRIG-B encoder item queue
// Two-entry queue of decoded items between front end and sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "irig_b_frame_pulse_encoder_assert.svh"

module irigb_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  irigb_pkg::item_t item_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output irigb_pkg::item_t item_o
);

  irigb_pkg::item_t mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  `IRIGB_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= 2'd2)
  `IRIGB_ASSERT_IMPL(a_ptr_match, clk_i, rst_ni, count_q != 2'd1, wr_ptr_q == rd_ptr_q)

endmodule

@@ hw/rtl/irigb_back.sv @@
// ----------------------------------------------------------------------------
// IRIG-B encoder sequencer
// Holds the time stamp and frame position, plays out pulse-width symbols.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "irig_b_frame_pulse_encoder_assert.svh"

module irigb_back #(
  parameter int unsigned FRAME_SYMBOLS   = 99,
  parameter int unsigned TICK_COUNT_BITS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  irigb_pkg::cfg_t  cfg_i,
  input  logic             valid_i,
  input  irigb_pkg::item_t item_i,
  output logic             pop_o,
  irigb_out_if.source      out_o
);

  localparam int unsigned CW = ((TICK_COUNT_BITS > irigb_pkg::CFG_W) ?
                                TICK_COUNT_BITS : irigb_pkg::CFG_W) + 1;

  typedef struct packed {
    logic                         level;
    logic                         busy;
    logic [irigb_pkg::POS_W-1:0]  pos;
    irigb_pkg::kind_e             kind;
    logic                         done;
    irigb_pkg::status_e           status;
  } res_t;

  function automatic irigb_pkg::kind_e kind_at(
    input logic [6:0] p,
    input logic [6:0] sec,
    input logic [6:0] mnt,
    input logic [6:0] hr,
    input logic [9:0] doy,
    input logic [7:0] yr
  );
    logic b;
    b = 1'b0;
    if (p == 7'd0 || p == 7'd1 || p == 7'd10 || p == 7'd20 || p == 7'd30 ||
        p == 7'd40 || p == 7'd50 || p == 7'd60 || p == 7'd70 || p == 7'd80 ||
        p == 7'd90) begin
      return irigb_pkg::KIND_MARKER;
    end
    if (p >= 7'd2 && p <= 7'd5) begin
      b = sec[3'(p - 7'd2)];
    end else if (p >= 7'd7 && p <= 7'd9) begin
      b = sec[3'(p - 7'd3)];
    end else if (p >= 7'd11 && p <= 7'd14) begin
      b = mnt[3'(p - 7'd11)];
    end else if (p >= 7'd16 && p <= 7'd18) begin
      b = mnt[3'(p - 7'd12)];
    end else if (p >= 7'd21 && p <= 7'd24) begin
      b = hr[3'(p - 7'd21)];
    end else if (p >= 7'd26 && p <= 7'd28) begin
      b = hr[3'(p - 7'd22)];
    end else if (p >= 7'd31 && p <= 7'd34) begin
      b = doy[4'(p - 7'd31)];
    end else if (p >= 7'd36 && p <= 7'd39) begin
      b = doy[4'(p - 7'd32)];
    end else if (p >= 7'd41 && p <= 7'd42) begin
      b = doy[4'(p - 7'd33)];
    end else if (p >= 7'd51 && p <= 7'd54) begin
      b = yr[3'(p - 7'd51)];
    end else if (p >= 7'd56 && p <= 7'd59) begin
      b = yr[3'(p - 7'd52)];
    end
    return b ? irigb_pkg::KIND_ONE : irigb_pkg::KIND_ZERO;
  endfunction

  logic [6:0]                 sec_q, sec_d, min_q, min_d, hr_q, hr_d;
  logic [9:0]                 doy_q, doy_d;
  logic [7:0]                 yr_q, yr_d;
  logic [irigb_pkg::POS_W-1:0] pos_q, pos_d;
  logic [TICK_COUNT_BITS-1:0] cnt_q, cnt_d;
  logic                       emit_q, emit_d;
  logic                       out_valid_q, out_valid_d;
  res_t                       res_q, res_d;

  irigb_pkg::kind_e           kind;
  logic [irigb_pkg::CFG_W-1:0] high;
  logic [CW-1:0]              eff, cnt_inc;
  logic                       slot_end, frame_end, level;

  assign pop_o = valid_i && (!out_valid_q || out_o.ready);

  assign kind = kind_at(pos_q, sec_q, min_q, hr_q, doy_q, yr_q);

  always_comb begin
    case (kind)
      irigb_pkg::KIND_MARKER: high = cfg_i.marker_high;
      irigb_pkg::KIND_ONE:    high = cfg_i.one_high;
      default:                high = cfg_i.zero_high;
    endcase
  end

  assign eff       = CW'((cfg_i.slot_ticks == '0) ? irigb_pkg::CFG_W'(1) : cfg_i.slot_ticks);
  assign cnt_inc   = CW'(cnt_q) + CW'(1);
  // a full counter also closes the slot
  assign slot_end  = (cnt_inc >= eff) || (&cnt_q);
  assign frame_end = (8'(pos_q) + 8'd1) >= 8'(FRAME_SYMBOLS);
  assign level     = CW'(cnt_q) < CW'(high);

  always_comb begin
    sec_d  = sec_q;
    min_d  = min_q;
    hr_d   = hr_q;
    doy_d  = doy_q;
    yr_d   = yr_q;
    pos_d  = pos_q;
    cnt_d  = cnt_q;
    emit_d = emit_q;
    res_d  = '0;
    if (pop_o) begin
      unique case (item_i.op)
        irigb_pkg::OP_LOAD: begin
          res_d.pos = pos_q;
          if (emit_q) begin
            res_d.status = irigb_pkg::ST_BUSY;
            res_d.busy   = 1'b1;
          end else if (item_i.bad_month) begin
            res_d.status = irigb_pkg::ST_BAD_MONTH;
          end else begin
            sec_d      = item_i.sec_bcd;
            min_d      = item_i.min_bcd;
            hr_d       = item_i.hr_bcd;
            doy_d      = item_i.doy_bcd;
            yr_d       = item_i.yr_bcd;
            pos_d      = '0;
            cnt_d      = '0;
            emit_d     = 1'b1;
            res_d.busy = 1'b1;
            res_d.pos  = '0;
          end
        end
        irigb_pkg::OP_TICK: begin
          if (emit_q) begin
            res_d.level = level;
            res_d.busy  = 1'b1;
            res_d.pos   = pos_q;
            res_d.kind  = kind;
            if (slot_end) begin
              cnt_d = '0;
              if (frame_end) begin
                res_d.done = 1'b1;
                emit_d     = 1'b0;
                pos_d      = '0;
              end else begin
                pos_d = pos_q + irigb_pkg::POS_W'(1);
              end
            end else begin
              cnt_d = cnt_q + TICK_COUNT_BITS'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_d = pop_o || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q       <= '0;
      min_q       <= '0;
      hr_q        <= '0;
      doy_q       <= '0;
      yr_q        <= '0;
      pos_q       <= '0;
      cnt_q       <= '0;
      emit_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sec_q       <= sec_d;
      min_q       <= min_d;
      hr_q        <= hr_d;
      doy_q       <= doy_d;
      yr_q        <= yr_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      emit_q      <= emit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.line_level      = res_q.level;
  assign out_o.busy_res        = res_q.busy;
  assign out_o.symbol_position = res_q.pos;
  assign out_o.symbol_kind     = res_q.kind;
  assign out_o.frame_done      = res_q.done;
  assign out_o.status          = res_q.status;

  `IRIGB_ASSERT_IMPL(a_idle_home, clk_i, rst_ni, !emit_q, pos_q == '0 && cnt_q == '0)
  `IRIGB_ASSERT_IMPL(a_pos_range, clk_i, rst_ni, emit_q, 8'(pos_q) < 8'(FRAME_SYMBOLS))
  `IRIGB_ASSERT_IMPL(a_done_busy, clk_i, rst_ni, out_valid_q && res_q.done, res_q.busy && !emit_q)

endmodule

@@ hw/rtl/irig_b_frame_pulse_encoder.sv @@
// ----------------------------------------------------------------------------
// IRIG-B frame pulse encoder
// Time-code frame generator with pulse-width symbol output per tick item.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries items: operation 1 loads a time stamp (seconds..year),
//   operation 0 is one tick. out_o returns exactly one result per item:
//   line level, busy flag, symbol position and kind, frame done, status.
//   The APB port sets slot length and the high times of zero, one and
//   marker symbols; write it only while no frame is playing.
//   Path: an accepted item is written into the queue, then the sequencer
//   registers its result in the output register, which drives out_o.
//   Throughput: one item per cycle while the receiver keeps out_o.ready high;
//   the front end decodes the time stamp, a two-entry queue feeds the
//   sequencer, which retires one item a cycle into the output register.
//   Reset: no frame in progress, position zero, registers at defaults
//   (slot 10, zero 2, one 5, marker 8 ticks).
//   Receiver stall: the result holds in the output register, the queue
//   absorbs up to two more items, then in_i.ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module irig_b_frame_pulse_encoder #(
  parameter int unsigned FRAME_SYMBOLS   = 99,
  parameter int unsigned TICK_COUNT_BITS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  irigb_in_if.sink                        in_i,
  irigb_out_if.source                     out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [irigb_pkg::ADDR_W-1:0]    paddr,
  input  logic [irigb_pkg::DATA_W-1:0]    pwdata,
  output logic [irigb_pkg::DATA_W-1:0]    prdata,
  output logic                            pready
);

  irigb_pkg::cfg_t   cfg_q, cfg_d;
  irigb_pkg::item_t  front_item, head_item;
  irigb_pkg::reg_idx_e reg_idx;
  logic              push, full, head_valid, pop, wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = irigb_pkg::reg_idx_e'(paddr[3:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        irigb_pkg::REG_SLOT_TICKS:  cfg_d.slot_ticks  = pwdata[irigb_pkg::CFG_W-1:0];
        irigb_pkg::REG_ZERO_HIGH:   cfg_d.zero_high   = pwdata[irigb_pkg::CFG_W-1:0];
        irigb_pkg::REG_ONE_HIGH:    cfg_d.one_high    = pwdata[irigb_pkg::CFG_W-1:0];
        irigb_pkg::REG_MARKER_HIGH: cfg_d.marker_high = pwdata[irigb_pkg::CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      irigb_pkg::REG_SLOT_TICKS:  prdata = irigb_pkg::DATA_W'(cfg_q.slot_ticks);
      irigb_pkg::REG_ZERO_HIGH:   prdata = irigb_pkg::DATA_W'(cfg_q.zero_high);
      irigb_pkg::REG_ONE_HIGH:    prdata = irigb_pkg::DATA_W'(cfg_q.one_high);
      irigb_pkg::REG_MARKER_HIGH: prdata = irigb_pkg::DATA_W'(cfg_q.marker_high);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slot_ticks  <= irigb_pkg::SLOT_TICKS_RST;
      cfg_q.zero_high   <= irigb_pkg::ZERO_HIGH_RST;
      cfg_q.one_high    <= irigb_pkg::ONE_HIGH_RST;
      cfg_q.marker_high <= irigb_pkg::MARKER_HIGH_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  irigb_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .item_o (front_item)
  );

  irigb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .item_o  (head_item)
  );

  irigb_back #(
    .FRAME_SYMBOLS   (FRAME_SYMBOLS),
    .TICK_COUNT_BITS (TICK_COUNT_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (head_valid),
    .item_i  (head_item),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

@@ dv/irig_b_frame_pulse_encoder_test.sv @@
// ----------------------------------------------------------------------------
// IRIG-B frame pulse encoder testbench
// Drives tick and load items into the encoder and predicts every result
// item by item. Each result is checked field by field, in order. The
// register settings change between phases: reset values, the extremes,
// zero-length slots, high times longer than the slot and one change made
// in the middle of a slot. Loads carry valid and out-of-range time stamps.
// Both channels stall at random, and there is one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module irig_b_frame_pulse_encoder_test;

  localparam int unsigned FRAME_LEN = 99;
  localparam int unsigned DAYS_IN_MONTH [12] = '{31, 28, 31, 30, 31, 30,
                                                 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    irigb_pkg::op_e op;
    logic [5:0]     sec;
    logic [5:0]     min;
    logic [4:0]     hr;
    logic [4:0]     day;
    logic [3:0]     mon;
    logic [6:0]     yr;
  } stamp_item_t;

  typedef struct packed {
    logic               line_level;
    logic               busy;
    logic [6:0]         pos;
    irigb_pkg::kind_e   kind;
    logic               done;
    irigb_pkg::status_e status;
  } pulse_res_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [irigb_pkg::ADDR_W-1:0]   paddr;
  logic [irigb_pkg::DATA_W-1:0]   pwdata;
  logic [irigb_pkg::DATA_W-1:0]   prdata;
  logic                           pready;

  irigb_in_if  in_if ();
  irigb_out_if out_if ();

  irig_b_frame_pulse_encoder uut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predicted encoder state and register copy
  logic [7:0]  cfg_slot;
  logic [7:0]  cfg_zero;
  logic [7:0]  cfg_one;
  logic [7:0]  cfg_marker;
  logic [6:0]  sec_bcd;
  logic [6:0]  min_bcd;
  logic [6:0]  hr_bcd;
  logic [9:0]  doy_bcd;
  logic [7:0]  yr_bcd;
  int unsigned cur_pos;
  int unsigned tick_cnt;
  bit          frame_active;

  pulse_res_t pending_results [$];
  int         fail_count = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         hold_off_req = 0;
  int         hold_off_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [7:0] to_bcd(input int unsigned v, input int unsigned tens_bits);
    int unsigned tens;
    tens = (v / 10) & ((1 << tens_bits) - 1);
    return 8'((v % 10) | (tens << 4));
  endfunction

  function automatic irigb_pkg::kind_e symbol_at(input int unsigned p);
    logic b;
    b = 1'b0;
    if (p == 0 || p == 1 || p % 10 == 0) return irigb_pkg::KIND_MARKER;
    if (p >= 2 && p <= 5) b = sec_bcd[p - 2];
    else if (p >= 7 && p <= 9) b = sec_bcd[p - 3];
    else if (p >= 11 && p <= 14) b = min_bcd[p - 11];
    else if (p >= 16 && p <= 18) b = min_bcd[p - 12];
    else if (p >= 21 && p <= 24) b = hr_bcd[p - 21];
    else if (p >= 26 && p <= 28) b = hr_bcd[p - 22];
    else if (p >= 31 && p <= 34) b = doy_bcd[p - 31];
    else if (p >= 36 && p <= 39) b = doy_bcd[p - 32];
    else if (p >= 41 && p <= 42) b = doy_bcd[p - 33];
    else if (p >= 51 && p <= 54) b = yr_bcd[p - 51];
    else if (p >= 56 && p <= 59) b = yr_bcd[p - 52];
    return b ? irigb_pkg::KIND_ONE : irigb_pkg::KIND_ZERO;
  endfunction

  function automatic pulse_res_t advance_encoder(input stamp_item_t it);
    pulse_res_t       r;
    int unsigned      doy;
    int unsigned      eff;
    int unsigned      high;
    int unsigned      p;
    irigb_pkg::kind_e k;
    r = '0;
    p = cur_pos;
    if (it.op == irigb_pkg::OP_LOAD) begin
      if (frame_active) begin
        r.status = irigb_pkg::ST_BUSY;
      end else if (it.mon < 1 || it.mon > 12) begin
        r.status = irigb_pkg::ST_BAD_MONTH;
      end else begin
        doy = it.day;
        for (int i = 0; i + 1 < it.mon; i++) begin
          doy += DAYS_IN_MONTH[i];
          if (i == 1 && (it.yr % 4) == 0) doy += 1;
        end
        sec_bcd = 7'(to_bcd(it.sec, 3));
        min_bcd = 7'(to_bcd(it.min, 3));
        hr_bcd = 7'(to_bcd(it.hr, 3));
        yr_bcd = to_bcd(it.yr, 4);
        doy_bcd = 10'((doy % 10) | (((doy / 10) % 10) << 4) | (((doy / 100) & 3) << 8));
        cur_pos = 0;
        tick_cnt = 0;
        frame_active = 1'b1;
      end
      p = cur_pos;
    end else if (frame_active) begin
      eff = (cfg_slot == 0) ? 1 : cfg_slot;
      k = symbol_at(p);
      if (k == irigb_pkg::KIND_MARKER) high = cfg_marker;
      else if (k == irigb_pkg::KIND_ONE) high = cfg_one;
      else high = cfg_zero;
      r.kind = k;
      r.line_level = (tick_cnt < high);
      if (tick_cnt + 1 >= eff) begin
        tick_cnt = 0;
        if (p + 1 >= FRAME_LEN) begin
          r.done = 1'b1;
          frame_active = 1'b0;
          cur_pos = 0;
        end else begin
          cur_pos = p + 1;
        end
      end else begin
        tick_cnt = (tick_cnt + 1) & 8'hff;
      end
    end else begin
      p = 0;
    end
    r.pos = 7'(p);
    r.busy = frame_active || r.done;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count++;
    if (fail_count <= 40)
      $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
  endtask

  // Result checker and receiver stall control
  always @(posedge clk) begin
    pulse_res_t want;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = pending_results.pop_front();
          if (out_if.line_level !== want.line_level)
            report_mismatch("line_level", out_if.line_level, want.line_level);
          if (out_if.busy_res !== want.busy)
            report_mismatch("busy_res", out_if.busy_res, want.busy);
          if (out_if.symbol_position !== want.pos)
            report_mismatch("symbol_position", out_if.symbol_position, want.pos);
          if (out_if.symbol_kind !== want.kind)
            report_mismatch("symbol_kind", out_if.symbol_kind, want.kind);
          if (out_if.frame_done !== want.done)
            report_mismatch("frame_done", out_if.frame_done, want.done);
          if (out_if.status !== want.status)
            report_mismatch("status", out_if.status, want.status);
        end
      end
      if (hold_off_req > 0) begin
        hold_off_left = hold_off_req;
        hold_off_req = 0;
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end else begin
      out_if.ready <= 1'b0;
    end
  end

  function automatic stamp_item_t load_of(input int sec, input int min, input int hr,
                                          input int day, input int mon, input int yr);
    stamp_item_t it;
    it.op = irigb_pkg::OP_LOAD;
    it.sec = 6'(sec);
    it.min = 6'(min);
    it.hr = 5'(hr);
    it.day = 5'(day);
    it.mon = 4'(mon);
    it.yr = 7'(yr);
    return it;
  endfunction

  function automatic stamp_item_t raw_stamp();
    return load_of($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  function automatic stamp_item_t good_stamp();
    return load_of($urandom_range(59), $urandom_range(59), $urandom_range(23),
                   $urandom_range(31, 1), $urandom_range(12, 1), $urandom_range(99));
  endfunction

  function automatic stamp_item_t tick_item();
    stamp_item_t it;
    it = raw_stamp();
    it.op = irigb_pkg::OP_TICK;
    return it;
  endfunction

  task automatic send_item(input stamp_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.operation <= it.op;
    in_if.seconds <= it.sec;
    in_if.minutes <= it.min;
    in_if.hours <= it.hr;
    in_if.day_of_month <= it.day;
    in_if.month <= it.mon;
    in_if.year <= it.yr;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pending_results.push_back(advance_encoder(it));
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_register(input irigb_pkg::reg_idx_e idx, input logic [7:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      irigb_pkg::REG_SLOT_TICKS:  cfg_slot = val;
      irigb_pkg::REG_ZERO_HIGH:   cfg_zero = val;
      irigb_pkg::REG_ONE_HIGH:    cfg_one = val;
      irigb_pkg::REG_MARKER_HIGH: cfg_marker = val;
    endcase
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {24'h0, val}) report_mismatch("register readback", prdata, val);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input int slot, input int zero, input int one, input int marker);
    drain_results();
    write_register(irigb_pkg::REG_SLOT_TICKS, 8'(slot));
    write_register(irigb_pkg::REG_ZERO_HIGH, 8'(zero));
    write_register(irigb_pkg::REG_ONE_HIGH, 8'(one));
    write_register(irigb_pkg::REG_MARKER_HIGH, 8'(marker));
  endtask

  task automatic finish_frame();
    while (frame_active) send_item(tick_item());
  endtask

  // Mostly well-formed loads followed by full frames of ticks, with noise
  task automatic run_frames(input int n_items);
    int r;
    for (int n = 0; n < n_items; n++) begin
      r = $urandom_range(99);
      if (frame_active) begin
        if (r < 3) send_item(raw_stamp());
        else send_item(tick_item());
      end else begin
        if (r < 8) send_item(tick_item());
        else if (r < 22) send_item(raw_stamp());
        else send_item(good_stamp());
      end
    end
  endtask

  task automatic test_directed();
    send_item(tick_item());
    send_item(load_of(0, 0, 0, 1, 0, 0));
    send_item(load_of(63, 63, 31, 31, 13, 127));
    send_item(load_of(59, 59, 23, 31, 15, 99));
    send_item(load_of(63, 63, 31, 31, 12, 127));
    send_item(load_of(0, 0, 0, 1, 1, 0));
    send_item(load_of(0, 0, 0, 1, 0, 0));
    repeat (12) send_item(tick_item());
    // slot shortened below the current tick count, then zero length
    drain_results();
    write_register(irigb_pkg::REG_SLOT_TICKS, 8'd1);
    repeat (2) send_item(tick_item());
    drain_results();
    write_register(irigb_pkg::REG_SLOT_TICKS, 8'd0);
    repeat (3) send_item(tick_item());
    finish_frame();
  endtask

  task automatic test_random(input int slot, input int zero, input int one, input int marker,
                             input int n_items);
    configure(slot, zero, one, marker);
    run_frames(n_items);
    finish_frame();
  endtask

  task automatic test_backpressure();
    int saved;
    drain_results();
    saved = send_idle_pct;
    send_idle_pct = 0;
    hold_off_req = 60;
    send_item(good_stamp());
    repeat (40) send_item(tick_item());
    send_idle_pct = saved;
    finish_frame();
    drain_results();
  endtask

  task automatic test_long_slot();
    configure(255, 0, 255, 254);
    send_item(load_of(37, 48, 19, 29, 2, 96));
    repeat (260) send_item(tick_item());
  endtask

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.operation = irigb_pkg::OP_TICK;
    in_if.seconds = '0;
    in_if.minutes = '0;
    in_if.hours = '0;
    in_if.day_of_month = '0;
    in_if.month = '0;
    in_if.year = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg_slot = irigb_pkg::SLOT_TICKS_RST;
    cfg_zero = irigb_pkg::ZERO_HIGH_RST;
    cfg_one = irigb_pkg::ONE_HIGH_RST;
    cfg_marker = irigb_pkg::MARKER_HIGH_RST;
    sec_bcd = '0;
    min_bcd = '0;
    hr_bcd = '0;
    doy_bcd = '0;
    yr_bcd = '0;
    cur_pos = 0;
    tick_cnt = 0;
    frame_active = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 12;
    recv_idle_pct = 67;
    test_directed();
    test_random(1, 0, 1, 1, 80);
    test_random(2, $urandom_range(3), $urandom_range(3), $urandom_range(3), 40);

    send_idle_pct = 67;
    recv_idle_pct = 12;
    test_random(0, 255, 128, 0, 60);
    test_random(1, $urandom_range(6), $urandom_range(6), $urandom_range(6), 40);
    test_backpressure();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_long_slot();

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
